// ===== rtl/sorted_priority_queue_top_macros.svh =====
// Assertion macros for the checker file of the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Checked at every rising edge of i_clk, with reset masking the check.
`define SPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define SPQ_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = 32;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_FIND,
        S_SHIFT,
        S_DISP,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sorted_priority_queue_top.sv =====
// Channel  Direction  tdata            tuser          tlast
// s        in         value [31:0]     opcode [1:0]   -
// m        out        entry [31:0]     status [1:0]   last result of the item
//
// The entries sit in one memory with one write and one registered read port.
// An insert walks down from the top entry, one shift per cycle. A delete scans
// upward and then shifts the tail down. A display sends each entry in turn and
// holds while the output is stalled. Reset clears only the fill count, the control
// state, the read valid flag and the output valid. A stalled output holds its
// transfer; the next item is taken once the last result sits in the output register.
`default_nettype none

module sorted_priority_queue_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    input  wire  [spq_pkg::DATA_W-1:0]    i_s_tdata,   // value
    input  wire  [spq_pkg::OP_W-1:0]      i_s_tuser,   // opcode
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    output logic [spq_pkg::DATA_W-1:0]    o_m_tdata,   // entry
    output logic [spq_pkg::STAT_W-1:0]    o_m_tuser,   // status
    output logic                          o_m_tlast
);
    import spq_pkg::*;

    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_rdata;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_ptr, n_ptr;
    logic                   r_rv, n_rv;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [DATA_W-1:0]      r_res, n_res;
    t_status                r_status, n_status;
    logic                   r_ovalid, n_ovalid;
    logic [DATA_W-1:0]      r_oentry, n_oentry;
    t_status                r_ostatus, n_ostatus;
    logic                   r_olast, n_olast;

    logic                   we, re, hold, out_free, last_idx, gt;
    logic [IDX_W-1:0]       waddr, raddr;
    logic [VALUE_WIDTH-1:0] wdata, in_val;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rv     <= n_rv;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_val     <= n_val;
        r_res     <= n_res;
        r_status  <= n_status;
        r_oentry  <= n_oentry;
        r_ostatus <= n_ostatus;
        r_olast   <= n_olast;
    end

    assign in_val   = VALUE_WIDTH'($signed(i_s_tdata));
    assign out_free = !r_ovalid || i_m_tready;
    assign last_idx = (CNT_W'(r_ptr) == r_count - 1'b1);
    assign gt       = $signed(r_rdata) > $signed(r_val);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_val     = r_val;
        n_res     = r_res;
        n_status  = r_status;
        n_oentry  = r_oentry;
        n_ostatus = r_ostatus;
        n_olast   = r_olast;
        n_ovalid  = r_ovalid && !i_m_tready;
        we        = 1'b0;
        waddr     = '0;
        wdata     = r_val;
        re        = 1'b0;
        raddr     = r_ptr;
        hold      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_val    = in_val;
                    n_res    = i_s_tdata;
                    n_ptr    = '0;
                    n_status = ST_OK;
                    case (i_s_tuser)
                        OP_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                we      = 1'b1;
                                wdata   = in_val;
                                n_count = r_count + 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_ptr   = IDX_W'(r_count - 1'b1);
                                n_state = S_INS;
                            end
                        end
                        OP_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        OP_DISPLAY: begin
                            if (r_count == '0) begin
                                n_res    = '0;
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_DISP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (!r_rv) begin
                    re = 1'b1;
                end else if (gt) begin
                    we    = 1'b1;
                    waddr = r_ptr + 1'b1;
                    wdata = r_rdata;
                    if (r_ptr == '0) begin
                        n_state = S_PUT;
                    end else begin
                        re    = 1'b1;
                        raddr = r_ptr - 1'b1;
                        n_ptr = r_ptr - 1'b1;
                    end
                end else begin
                    we      = 1'b1;
                    waddr   = r_ptr + 1'b1;
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_PUT: begin
                we      = 1'b1;
                n_count = r_count + 1'b1;
                n_state = S_DONE;
            end
            S_FIND: begin
                if (!r_rv) begin
                    re = 1'b1;
                end else if (r_rdata == r_val) begin
                    if (last_idx) begin
                        n_count = r_count - 1'b1;
                        n_state = S_DONE;
                    end else begin
                        re      = 1'b1;
                        raddr   = r_ptr + 1'b1;
                        n_ptr   = r_ptr + 1'b1;
                        n_state = S_SHIFT;
                    end
                end else if (last_idx) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    re    = 1'b1;
                    raddr = r_ptr + 1'b1;
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_SHIFT: begin
                we    = 1'b1;
                waddr = r_ptr - 1'b1;
                wdata = r_rdata;
                if (last_idx) begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end else begin
                    re    = 1'b1;
                    raddr = r_ptr + 1'b1;
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_DISP: begin
                if (!r_rv) begin
                    re = 1'b1;
                end else if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_oentry  = DATA_W'(r_rdata);
                    n_ostatus = ST_OK;
                    n_olast   = last_idx;
                    if (last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        re    = 1'b1;
                        raddr = r_ptr + 1'b1;
                        n_ptr = r_ptr + 1'b1;
                    end
                end else begin
                    hold = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_oentry  = r_res;
                    n_ostatus = r_status;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rv = hold ? r_rv : re;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_oentry;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

// ===== rtl/spq_checker.sv =====
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"

module spq_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_s_tvalid,
    input wire                           o_s_tready,
    input wire [spq_pkg::OP_W-1:0]       i_s_tuser,
    input wire                           o_m_tvalid,
    input wire [spq_pkg::STAT_W-1:0]     o_m_tuser,
    input wire                           o_m_tlast
);
    import spq_pkg::*;

    wire mid_result = o_m_tvalid && !o_m_tlast;
    wire op_taken   = i_s_tvalid && o_s_tready && (i_s_tuser != OP_NONE);

    // A result that is not the last one belongs to a display still in progress.
    `SPQ_ASSERT(a_mid_display_busy, mid_result |-> !o_s_tready, "input taken mid display")
    `SPQ_ASSERT(a_mid_display_ok, mid_result |-> o_m_tuser == ST_OK, "bad status mid display")
    `SPQ_ASSERT(a_busy_after_op, op_taken |=> !o_s_tready, "ready after a transfer")
    `SPQ_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (.*);

`default_nettype wire
